FILE: sv/smig_pkg.sv
// shared types and constants of the sphere mesh index generator
// no dependencies
package smig_pkg;

  localparam int IDX_W      = 13;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;

  localparam logic [CFG_W-1:0] COLUMNS_RESET = 7'd16;
  localparam logic [CFG_W-1:0] ROWS_RESET    = 7'd8;

  typedef enum logic [2:0] {
    PH_SOUTH = 3'b001,
    PH_BAND  = 3'b010,
    PH_NORTH = 3'b100
  } smig_phase_t;

  typedef struct packed {
    logic rewind;
  } smig_cmd_t;

endpackage

FILE: sv/smig_front.sv
// input side: accepts items, turns them into commands and queues them
// depends on smig_pkg
module smig_front import smig_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      restart,
  output logic      q_valid,
  input  logic      q_ready,
  output smig_cmd_t q_cmd
);

  smig_cmd_t  slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_cmd    = slots[rp];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp].rewind <= restart;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

FILE: sv/smig_back.sv
// sequencer: mesh counters, configuration registers and triangle output register
// depends on smig_pkg
module smig_back import smig_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  smig_cmd_t            q_cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     index_a,
  output logic [IDX_W-1:0]     index_b,
  output logic [IDX_W-1:0]     index_c,
  output logic                 last_triangle
);

  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int XW = $clog2(MAX_COLUMNS);
  localparam int YW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SW = CW + RW + 1;
  localparam int IW = (SW > IDX_W) ? SW : IDX_W;

  function automatic logic [CW-1:0] sat_cols(logic [CFG_W-1:0] v);
    logic [8:0] w;
    logic [8:0] m;
    w = {2'b00, v};
    m = 9'(MAX_COLUMNS);
    if (w == 9'd0) w = 9'd1;
    if (w > m) w = m;
    return w[CW-1:0];
  endfunction

  function automatic logic [RW-1:0] sat_rows(logic [CFG_W-1:0] v);
    logic [8:0] w;
    logic [8:0] m;
    w = {2'b00, v};
    m = 9'(MAX_ROWS);
    if (w == 9'd0) w = 9'd1;
    if (w > m) w = m;
    return w[RW-1:0];
  endfunction

  function automatic logic [CW-1:0] wrap(logic [CW:0] v, logic [CW-1:0] cc);
    logic [CW:0] ce;
    logic [CW:0] w;
    ce = {1'b0, cc};
    w  = v;
    if (w >= ce) w = w - ce;
    if (w >= ce) w = w - ce;
    return w[CW-1:0];
  endfunction

  logic [CW-1:0] cols;
  logic [RW-1:0] rws;
  smig_phase_t   phase, phase_next;
  logic [YW-1:0] ring_row, ring_row_next;
  logic [XW-1:0] ring_column, ring_column_next;
  logic          second_half, second_half_next;

  smig_phase_t   ph;
  logic [YW-1:0] y;
  logic [XW-1:0] x;
  logic          h;
  logic          bad;
  logic [CW:0]   x1;
  logic [CW:0]   x_off;
  logic [CW:0]   x1_off;
  logic          off;
  logic [SW-1:0] cr;
  logic [SW-1:0] lo;
  logic [SW-1:0] hi;
  logic [SW-1:0] base;
  logic [SW-1:0] a;
  logic [SW-1:0] b;
  logic [SW-1:0] t;
  logic          last;
  logic          pop;

  assign q_ready = !out_valid || out_ready;
  assign pop     = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols <= sat_cols(COLUMNS_RESET);
      rws  <= sat_rows(ROWS_RESET);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_COLUMNS) begin
        cols <= sat_cols(cfg_data);
      end else if (cfg_index == CFG_ROWS) begin
        rws <= sat_rows(cfg_data);
      end
    end
  end

  always_comb begin
    ph  = phase;
    y   = ring_row;
    x   = ring_column;
    h   = second_half;
    bad = (CW'(x) >= cols);
    case (phase)
      PH_SOUTH, PH_NORTH: bad = bad || (y != '0);
      PH_BAND:            bad = bad || ((RW+1)'(y) + (RW+1)'(1) >= (RW+1)'(rws));
      default:            bad = 1'b1;
    endcase
    if (q_cmd.rewind || bad) begin
      ph = PH_SOUTH;
      y  = '0;
      x  = '0;
      h  = 1'b0;
    end

    off    = y[0] && (ph == PH_BAND);
    x1     = (CW+1)'(x) + (CW+1)'(1);
    x_off  = (CW+1)'(x) + (CW+1)'(off);
    x1_off = x1 + (CW+1)'(off);
    cr     = SW'(cols) * SW'(rws);
    lo     = SW'(y) * SW'(cols);
    hi     = lo + SW'(cols);
    base   = cr - SW'(cols);

    phase_next       = ph;
    ring_row_next    = y;
    ring_column_next = x;
    second_half_next = h;
    last             = 1'b0;
    a                = '0;
    b                = '0;
    t                = '0;

    case (ph)
      PH_SOUTH: begin
        a = cr;
        b = SW'(x);
        t = SW'(wrap(x1, cols));
        if (x1 == (CW+1)'(cols)) begin
          ring_column_next = '0;
          phase_next       = (rws > RW'(1)) ? PH_BAND : PH_NORTH;
        end else begin
          ring_column_next = XW'(x1);
        end
      end
      PH_BAND: begin
        t = lo + SW'(wrap(x1, cols));
        if (!h) begin
          a = lo + SW'(x);
          b = hi + SW'(wrap(x_off, cols));
          second_half_next = 1'b1;
        end else begin
          a = hi + SW'(wrap(x_off, cols));
          b = hi + SW'(wrap(x1_off, cols));
          second_half_next = 1'b0;
          if (x1 == (CW+1)'(cols)) begin
            ring_column_next = '0;
            if ((RW+1)'(y) + (RW+1)'(2) >= (RW+1)'(rws)) begin
              ring_row_next = '0;
              phase_next    = PH_NORTH;
            end else begin
              ring_row_next = y + YW'(1);
            end
          end else begin
            ring_column_next = XW'(x1);
          end
        end
      end
      PH_NORTH: begin
        a = cr + SW'(1);
        b = base + SW'(wrap(x1, cols));
        t = base + SW'(x);
        if (x1 == (CW+1)'(cols)) begin
          last             = 1'b1;
          phase_next       = PH_SOUTH;
          ring_row_next    = '0;
          ring_column_next = '0;
          second_half_next = 1'b0;
        end else begin
          ring_column_next = XW'(x1);
        end
      end
      default: begin
        phase_next = PH_SOUTH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SOUTH;
      ring_row    <= '0;
      ring_column <= '0;
      second_half <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        phase       <= phase_next;
        ring_row    <= ring_row_next;
        ring_column <= ring_column_next;
        second_half <= second_half_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      index_a       <= IDX_W'(IW'(a));
      index_b       <= IDX_W'(IW'(b));
      index_c       <= IDX_W'(IW'(t));
      last_triangle <= last;
    end
  end

endmodule

FILE: sv/sphere_mesh_index_generator.sv
// top level of the sphere mesh index generator: command queue and sequencer
// depends on smig_pkg, smig_front, smig_back
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    restart
//   out      output     out_valid/out_ready  index_a, index_b, index_c, last_triangle
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one triangle per cycle while the output is not stalled; an item passes from the
// two-entry queue through the sequencer step into the output register
// the sequencer step is two products (columns times rows, row times columns) and wrap compares
// reset: synchronous, clears queue, counters and output valid; columns 16, rows 8
// either side may stall: the queue holds two items, the output register one
// cfg_ready is always high
module sphere_mesh_index_generator import smig_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 restart,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     index_a,
  output logic [IDX_W-1:0]     index_b,
  output logic [IDX_W-1:0]     index_c,
  output logic                 last_triangle,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic      q_valid;
  logic      q_ready;
  smig_cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  smig_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .restart  (restart),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  smig_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_cmd         (q_cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .index_a       (index_a),
    .index_b       (index_b),
    .index_c       (index_c),
    .last_triangle (last_triangle)
  );

endmodule

FILE: sv/smig_checker.sv
// port-level checks of the sphere mesh index generator, bound to the top level
// depends on smig_pkg and sphere_mesh_index_generator
module smig_checker import smig_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [IDX_W-1:0]     index_a,
  input logic [IDX_W-1:0]     index_b,
  input logic [IDX_W-1:0]     index_c,
  input logic                 last_triangle
);

  // a stalled triangle holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(index_a) && $stable(index_b)
      && $stable(index_c) && $stable(last_triangle))
    else $error("stalled triangle changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // the final triangle is a north fan triangle: pole index above both ring indices
  a_last_pole: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_triangle |-> (index_a > index_b) && (index_a > index_c))
    else $error("last triangle not around the north pole");

  // the queue fills only by taking an item
  a_full_needs_item: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("queue full with no item taken");

endmodule

bind sphere_mesh_index_generator smig_checker u_smig_checker (.*);

FILE: dv/tb_top.sv
// testbench of sphere_mesh_index_generator: directed and random triangle streams,
// each output triangle checked against a cycle-free mesh predictor
// depends on smig_pkg and the rtl of sphere_mesh_index_generator
module tb_top;
  import smig_pkg::*;

  localparam int MAX_COLS   = 64;
  localparam int MAX_RINGS  = 64;
  localparam int CYCLE_CAP  = 200000;
  localparam int RAND_ITEMS = 450;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
    logic [IDX_W-1:0] index_c;
    logic             last_triangle;
  } triangle_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic                 restart;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [IDX_W-1:0]     index_a;
  logic [IDX_W-1:0]     index_b;
  logic [IDX_W-1:0]     index_c;
  logic                 last_triangle;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // predictor state
  logic [CFG_W-1:0] gen_cols;
  logic [CFG_W-1:0] gen_rings;
  smig_phase_t      gen_phase;
  logic [5:0]       gen_row;
  logic [5:0]       gen_col;
  logic             gen_half;

  triangle_t pending_tris[$];
  int        fail_count = 0;
  int        cycle_count = 0;
  bit        idle_on = 1'b1;
  bit        stall_on = 1'b1;
  int        stall_left = 0;

  sphere_mesh_index_generator #(
    .MAX_COLUMNS(MAX_COLS),
    .MAX_ROWS   (MAX_RINGS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .index_a      (index_a),
    .index_b      (index_b),
    .index_c      (index_c),
    .last_triangle(last_triangle),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned wrap_ring(int unsigned v, int unsigned n);
    if (v >= n) v -= n;
    if (v >= n) v -= n;
    return v;
  endfunction

  function automatic void rewind_mesh();
    gen_phase = PH_SOUTH;
    gen_row   = '0;
    gen_col   = '0;
    gen_half  = 1'b0;
  endfunction

  function automatic triangle_t mesh_step(logic rewind);
    int unsigned nc, nr, x, y, off, lo, hi, base, a, b, c;
    bit          broken;
    triangle_t   t;
    nc = (gen_cols == 0) ? 1 : ((gen_cols > MAX_COLS) ? MAX_COLS : gen_cols);
    nr = (gen_rings == 0) ? 1 : ((gen_rings > MAX_RINGS) ? MAX_RINGS : gen_rings);
    a = 0;
    b = 0;
    c = 0;
    t = '0;
    x = 32'(gen_col);
    y = 32'(gen_row);
    broken = (gen_phase != PH_SOUTH && gen_phase != PH_BAND && gen_phase != PH_NORTH) ||
             (x >= nc) || (gen_phase == PH_BAND && y + 1 >= nr) ||
             (gen_phase != PH_BAND && y != 0);
    if (rewind || broken) rewind_mesh();
    x = 32'(gen_col);
    y = 32'(gen_row);
    case (gen_phase)
      PH_SOUTH: begin
        a = nc * nr;
        b = x;
        c = wrap_ring(x + 1, nc);
        if (x + 1 == nc) begin
          gen_col   = '0;
          gen_phase = (nr > 1) ? PH_BAND : PH_NORTH;
        end else begin
          gen_col = 6'(x + 1);
        end
      end
      PH_BAND: begin
        off = y & 1;
        lo  = y * nc;
        hi  = (y + 1) * nc;
        if (!gen_half) begin
          a = lo + x;
          b = hi + wrap_ring(x + off, nc);
          c = lo + wrap_ring(x + 1, nc);
          gen_half = 1'b1;
        end else begin
          a = hi + wrap_ring(x + off, nc);
          b = hi + wrap_ring(x + 1 + off, nc);
          c = lo + wrap_ring(x + 1, nc);
          gen_half = 1'b0;
          if (x + 1 == nc) begin
            gen_col = '0;
            if (y + 2 >= nr) begin
              gen_row   = '0;
              gen_phase = PH_NORTH;
            end else begin
              gen_row = 6'(y + 1);
            end
          end else begin
            gen_col = 6'(x + 1);
          end
        end
      end
      default: begin
        base = nc * (nr - 1);
        a = nc * nr + 1;
        b = base + wrap_ring(x + 1, nc);
        c = base + x;
        if (x + 1 == nc) begin
          t.last_triangle = 1'b1;
          rewind_mesh();
        end else begin
          gen_col = 6'(x + 1);
        end
      end
    endcase
    t.index_a = a[IDX_W-1:0];
    t.index_b = b[IDX_W-1:0];
    t.index_c = c[IDX_W-1:0];
    return t;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // register writes, item acceptance and result checking
  always @(posedge clk) begin
    triangle_t want;
    if (rst) begin
      gen_cols  = COLUMNS_RESET;
      gen_rings = ROWS_RESET;
      rewind_mesh();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COLUMNS: gen_cols = cfg_data;
          CFG_ROWS:    gen_rings = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) pending_tris.push_back(mesh_step(restart));
      if (out_valid && out_ready) begin
        if (pending_tris.size() == 0) begin
          $display("%0t: unexpected triangle, expected none actual %0d %0d %0d %0d", $time,
                   index_a, index_b, index_c, last_triangle);
          fail_count++;
        end else begin
          want = pending_tris.pop_front();
          compare_field("index_a", 32'(want.index_a), 32'(index_a));
          compare_field("index_b", 32'(want.index_b), 32'(index_b));
          compare_field("index_c", 32'(want.index_c), 32'(index_c));
          compare_field("last_triangle", 32'(want.last_triangle), 32'(last_triangle));
        end
      end
    end
  end

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic rewind);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rewind;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_mesh();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_tris.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_run(input int n);
    repeat (n) send_item(1'b0);
  endtask

  function automatic logic [CFG_W-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd64;
      3: return 7'd65;
      4: return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic test_reset_config();
    send_run(2);
  endtask

  task automatic test_single_row_column();
    drain_mesh();
    write_reg(CFG_COLUMNS, 7'd1);
    write_reg(CFG_ROWS, 7'd1);
    send_run(3);
    drain_mesh();
    write_reg(CFG_COLUMNS, 7'd3);
    send_run(4);
  endtask

  task automatic test_saturation();
    drain_mesh();
    write_reg(CFG_COLUMNS, 7'd0);
    write_reg(CFG_ROWS, 7'd127);
    send_run(3);
    drain_mesh();
    write_reg(CFG_COLUMNS, 7'd127);
    write_reg(CFG_ROWS, 7'd0);
    send_run(2);
  endtask

  task automatic test_restart();
    drain_mesh();
    write_reg(CFG_COLUMNS, 7'd2);
    write_reg(CFG_ROWS, 7'd2);
    send_run(3);
    send_item(1'b1);
    send_item(1'b1);
    send_run(1);
  endtask

  task automatic test_shrink_mid_mesh();
    drain_mesh();
    write_reg(CFG_COLUMNS, 7'd5);
    write_reg(CFG_ROWS, 7'd3);
    send_run(8);
    drain_mesh();
    write_reg(CFG_COLUMNS, 7'd2);
    write_reg(CFG_ROWS, 7'd2);
    send_run(2);
  endtask

  task automatic test_unused_index();
    drain_mesh();
    write_reg(CFG_SPARE2, 7'h7f);
    write_reg(CFG_SPARE3, 7'h55);
    send_run(1);
  endtask

  task automatic test_random_meshes();
    int  sent;
    int  n;
    bit  paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < RAND_ITEMS) begin
      drain_mesh();
      if (sent > 380) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(CFG_COLUMNS, pick_extreme());
        write_reg(CFG_ROWS, pick_extreme());
      end else begin
        if ($urandom_range(0, 3) != 0) write_reg(CFG_COLUMNS, 7'($urandom_range(1, 5)));
        if ($urandom_range(0, 3) != 0) write_reg(CFG_ROWS, 7'($urandom_range(1, 5)));
      end
      n = $urandom_range(10, 60);
      for (int k = 0; k < n; k++) begin
        if (!paused && sent > 100 && k == n / 2) begin
          drain_mesh();
          paused = 1'b1;
        end
        send_item($urandom_range(0, 31) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    restart   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_config();
    test_single_row_column();
    test_saturation();
    test_restart();
    test_shrink_mid_mesh();
    test_unused_index();
    test_random_meshes();
    drain_mesh();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_tris.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/smig_pkg.sv
sv/smig_front.sv
sv/smig_back.sv
sv/sphere_mesh_index_generator.sv
sv/smig_checker.sv
dv/tb_top.sv
